FILE: design/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// Depends on nothing; every other design file imports it.
package gsa_pkg;

    localparam int KIND_W = 2;
    localparam int HIDX_W = 10;
    localparam int HGEN_W = 16;
    localparam int LIVE_W = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch the request beat
        logic lookup_rd;  // read slot memory at the request handle index
        logic pop_rd;     // read the free stack top
        logic gen_rd;     // read slot memory at the popped index
        logic finish;     // commit state updates and load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic out_free;
    } status_t;

endpackage

FILE: design/gsa_req_if.sv
// Request channel of the slot allocator: valid/ready plus the request fields.
// Depends on gsa_pkg.
interface gsa_req_if
    import gsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0] handle_generation;

    modport source (
        output valid, kind, handle_index, handle_generation,
        input  ready
    );

    modport sink (
        input  valid, kind, handle_index, handle_generation,
        output ready
    );
endinterface

FILE: design/gsa_rsp_if.sv
// Result channel of the slot allocator: valid/ready plus the result fields.
// Depends on gsa_pkg.
interface gsa_rsp_if
    import gsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [HIDX_W-1:0] slot_index;
    logic [HGEN_W-1:0] slot_generation;
    logic [LIVE_W-1:0] live_slots;

    modport source (
        output valid, ok, slot_index, slot_generation, live_slots,
        input  ready
    );

    modport sink (
        input  valid, ok, slot_index, slot_generation, live_slots,
        output ready
    );
endinterface

FILE: design/gsa_ctrl.sv
// Sequencing state machine of the slot allocator.
// Depends on gsa_pkg; drives cmd_t to gsa_datapath and reads its status_t.
module gsa_ctrl
    import gsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] kind,
    output logic              in_ready,
    input  status_t           status,
    output cmd_t              cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_GEN_RD = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    kind_t  req_kind;

    assign req_kind = kind_t'(kind);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                    if (req_kind == KIND_ALLOC && !status.stack_empty)
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = ST_GEN_RD;
                    end
                    else if (req_kind inside {KIND_RELEASE, KIND_CHECK})
                    begin
                        cmd.lookup_rd = 1'b1;
                    end
                end
            end
            ST_GEN_RD:
            begin
                cmd.gen_rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/gsa_datapath.sv
// Datapath of the slot allocator: slot memory (in-use flag plus generation),
// free stack memory, counters, handle validation and the result register.
// Depends on gsa_pkg; sequenced by gsa_ctrl through cmd_t.
module gsa_datapath
    import gsa_pkg::*;
#(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [KIND_W-1:0] kind,
    input  logic [HIDX_W-1:0] handle_index,
    input  logic [HGEN_W-1:0] handle_generation,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [HIDX_W-1:0] slot_index,
    output logic [HGEN_W-1:0] slot_generation,
    output logic [LIVE_W-1:0] live_slots
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RNG_W = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
    localparam int CMP_W = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

    // slot memory word: {in_use, generation}
    logic [GEN_BITS:0]  slot_mem [SLOTS];
    logic [IDX_W-1:0]   free_stack [SLOTS];

    logic [CNT_W-1:0]   hw_reg, hw_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic               pop_reg;
    logic               out_valid_reg;

    kind_t              kind_reg;
    logic [HIDX_W-1:0]  hidx_reg;
    logic [HGEN_W-1:0]  hgen_reg;
    logic [IDX_W-1:0]   stack_top_reg;
    logic [GEN_BITS:0]  mem_q_reg;

    logic               ok_reg;
    logic [HIDX_W-1:0]  slot_index_reg;
    logic [HGEN_W-1:0]  slot_generation_reg;
    logic [LIVE_W-1:0]  live_slots_reg;

    logic               res_ok;
    logic [IDX_W-1:0]   res_idx;
    logic [GEN_BITS-1:0] res_gen;

    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [GEN_BITS:0]  mem_wdata;
    logic               stack_we;
    logic [IDX_W-1:0]   stack_rd_ptr;
    logic [IDX_W-1:0]   hidx_addr;
    logic [GEN_BITS-1:0] stored_gen;
    logic               handle_valid;

    assign status.stack_empty = (depth_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign hidx_addr    = IDX_W'(hidx_reg);
    assign stored_gen   = mem_q_reg[GEN_BITS-1:0];
    assign stack_rd_ptr = IDX_W'(depth_reg - CNT_W'(1));

    // entries at or above the high-water mark were never written since clear
    assign handle_valid = (RNG_W'(hidx_reg) < RNG_W'(hw_reg))
                       && mem_q_reg[GEN_BITS]
                       && (CMP_W'(stored_gen) == CMP_W'(hgen_reg));

    assign mem_re    = cmd.lookup_rd || cmd.gen_rd;
    assign mem_raddr = cmd.lookup_rd ? IDX_W'(handle_index) : stack_top_reg;

    always_comb
    begin
        hw_next    = hw_reg;
        depth_next = depth_reg;
        live_next  = live_reg;
        res_ok     = 1'b0;
        res_idx    = '0;
        res_gen    = '0;
        mem_we     = 1'b0;
        mem_waddr  = hidx_addr;
        mem_wdata  = {1'b0, GEN_BITS'(stored_gen + GEN_BITS'(1))};
        stack_we   = 1'b0;
        case (kind_reg)
            KIND_ALLOC:
            begin
                if (pop_reg)
                begin
                    res_ok     = 1'b1;
                    res_idx    = stack_top_reg;
                    res_gen    = stored_gen;
                    mem_we     = 1'b1;
                    mem_waddr  = stack_top_reg;
                    mem_wdata  = {1'b1, stored_gen};
                    depth_next = depth_reg - CNT_W'(1);
                    live_next  = live_reg + CNT_W'(1);
                end
                else if (hw_reg < CNT_W'(SLOTS))
                begin
                    res_ok    = 1'b1;
                    res_idx   = IDX_W'(hw_reg);
                    res_gen   = GEN_BITS'(1);
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(hw_reg);
                    mem_wdata = {1'b1, GEN_BITS'(1)};
                    hw_next   = hw_reg + CNT_W'(1);
                    live_next = live_reg + CNT_W'(1);
                end
            end
            KIND_RELEASE:
            begin
                if (handle_valid)
                begin
                    res_ok = 1'b1;
                    mem_we = 1'b1;
                    if (depth_reg < CNT_W'(SLOTS))
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - CNT_W'(1);
                    end
                end
            end
            KIND_CHECK:
            begin
                res_ok = handle_valid;
            end
            KIND_CLEAR:
            begin
                res_ok     = 1'b1;
                hw_next    = '0;
                depth_next = '0;
                live_next  = '0;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.finish && mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= slot_mem[mem_raddr];
        end
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.finish && stack_we)
        begin
            free_stack[IDX_W'(depth_reg)] <= hidx_addr;
        end
        if (cmd.pop_rd)
        begin
            stack_top_reg <= free_stack[stack_rd_ptr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            hidx_reg <= handle_index;
            hgen_reg <= handle_generation;
        end
        if (cmd.finish)
        begin
            ok_reg              <= res_ok;
            slot_index_reg      <= HIDX_W'(res_idx);
            slot_generation_reg <= HGEN_W'(res_gen);
            live_slots_reg      <= LIVE_W'(live_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= '0;
            depth_reg     <= '0;
            live_reg      <= '0;
            pop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                pop_reg <= cmd.pop_rd;
            end
            if (cmd.finish)
            begin
                hw_reg        <= hw_next;
                depth_reg     <= depth_next;
                live_reg      <= live_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                // drop the beat once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign slot_index      = slot_index_reg;
    assign slot_generation = slot_generation_reg;
    assign live_slots      = live_slots_reg;

endmodule

FILE: design/generational_slot_allocator_core.sv
// Generational slot allocator: hands out {index, generation} handles from a free
// stack or a high-water mark, and releases, checks and clears them. One request
// beat gives one result beat. Release, check, clear and allocate of a never-used
// slot go from ST_IDLE to ST_DONE; allocating a recycled slot adds ST_GEN_RD
// for two dependent synchronous reads (free stack top, then its generation). The
// result sits in an output register, so a new request is taken while it waits.
// Memories need no clearing pass after reset: the high-water mark guards them.
// Depends on gsa_pkg, gsa_req_if, gsa_rsp_if, gsa_ctrl and gsa_datapath.
module generational_slot_allocator_core
    import gsa_pkg::*;
#(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    gsa_req_if.sink   req,
    gsa_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    gsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .kind     (req.kind),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gsa_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .kind              (req.kind),
        .handle_index      (req.handle_index),
        .handle_generation (req.handle_generation),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .ok                (rsp.ok),
        .slot_index        (rsp.slot_index),
        .slot_generation   (rsp.slot_generation),
        .live_slots        (rsp.live_slots)
    );

endmodule
